// ----- src/mfd_pkg.sv -----
`timescale 1ns / 1ps

package mfd_pkg;

    // Width of the little-endian size field on the wire (4 to 8 bytes).
    localparam int SIZE_FIELD_BYTES = 4;

    // Header layout: magic (2), checksum, version, op, mask (4), size field
    localparam int POS_MAGIC_LO = 0;
    localparam int POS_MAGIC_HI = 1;
    localparam int POS_CSUM     = 2;
    localparam int POS_VERSION  = 3;
    localparam int POS_OP       = 4;
    localparam int POS_MASK0    = 5;
    localparam int POS_SIZE0    = 9;
    localparam int HEADER_BYTES = POS_SIZE0 + SIZE_FIELD_BYTES;
    localparam int POS_LAST     = HEADER_BYTES - 1;
    localparam int HDR_POS_W    = $clog2(HEADER_BYTES);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [HDR_POS_W-1:0] hdr_pos_t;

    typedef enum logic [2:0] {
        ST_HDR_BYTE    = 3'd0,
        ST_HDR_OK      = 3'd1,
        ST_PAYLOAD     = 3'd2,
        ST_BAD_MAGIC   = 3'd3,
        ST_BAD_VERSION = 3'd4,
        ST_SIZE_LARGE  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC    = 2'd0,
        REG_MAX_VER  = 2'd1,
        REG_MAX_SIZE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] magic;
        logic [7:0]  max_version;
        logic [31:0] max_size;
    } cfg_t;

    typedef struct packed {
        hdr_pos_t    hdr_pos;
        logic        in_payload;
        logic [7:0]  magic_lo;
        logic [7:0]  exp_csum;
        logic [7:0]  version;
        logic [7:0]  op;
        logic [31:0] mask;
        logic [31:0] size;
        logic [31:0] remaining;
        logic [7:0]  run_csum;
        logic [1:0]  mask_phase;
        logic        size_ovf;
    } parse_state_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  data_byte;
        logic [7:0]  frame_op;
        logic [7:0]  frame_version;
        logic [31:0] payload_size;
        logic        frame_end;
        logic        checksum_ok;
    } result_t;

endpackage

// ----- src/mfd_if.sv -----
`timescale 1ns / 1ps

interface mfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface mfd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [7:0]  frame_op;
    logic [7:0]  frame_version;
    logic [31:0] payload_size;
    logic        frame_end;
    logic        checksum_ok;

    modport source (output valid, output status, output data_byte, output frame_op,
                    output frame_version, output payload_size, output frame_end,
                    output checksum_ok, input ready);
    modport sink   (input valid, input status, input data_byte, input frame_op,
                    input frame_version, input payload_size, input frame_end,
                    input checksum_ok, output ready);
endinterface

interface mfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/mfd_cfg.sv -----
`timescale 1ns / 1ps

module mfd_cfg (
    input  logic          clk,
    input  logic          rst_n,
    mfd_cfg_if.sink       cfg_ch,
    output mfd_pkg::cfg_t cfg
);
    import mfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_MAGIC:    cfg_next.magic       = cfg_ch.data[15:0];
                REG_MAX_VER:  cfg_next.max_version = cfg_ch.data[7:0];
                REG_MAX_SIZE: cfg_next.max_size    = cfg_ch.data;
                default:      cfg_next             = cfg_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic       <= 16'h0000;
            cfg_reg.max_version <= 8'd1;
            cfg_reg.max_size    <= 32'hFFFF_FFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/mfd_step.sv -----
`timescale 1ns / 1ps

module mfd_step (
    input  mfd_pkg::parse_state_t cur,
    input  mfd_pkg::cfg_t         cfg,
    input  logic [7:0]            in_byte,
    output mfd_pkg::parse_state_t nxt,
    output mfd_pkg::result_t      res
);
    import mfd_pkg::*;

    logic [7:0] mask_b;
    logic [7:0] data;
    hdr_pos_t   p;

    always_comb
    begin
        nxt             = cur;
        p               = cur.hdr_pos;
        mask_b          = cur.mask[8*cur.mask_phase +: 8];
        data            = in_byte ^ mask_b;
        res.status      = ST_HDR_BYTE;
        res.data_byte   = 8'h00;
        res.frame_end   = 1'b0;
        res.checksum_ok = 1'b0;

        if (cur.in_payload)
        begin
            res.status     = ST_PAYLOAD;
            res.data_byte  = data;
            nxt.run_csum   = cur.run_csum ^ data;
            nxt.mask_phase = cur.mask_phase + 2'd1;
            nxt.remaining  = cur.remaining - 32'd1;
            if (cur.remaining == 32'd1)
            begin
                res.frame_end   = 1'b1;
                res.checksum_ok = ((cur.run_csum ^ data) == cur.exp_csum);
                nxt.in_payload  = 1'b0;
                nxt.hdr_pos     = '0;
            end
        end
        else
        begin
            nxt.hdr_pos = p + hdr_pos_t'(1);

            if (p == hdr_pos_t'(POS_MAGIC_LO))
            begin
                // new frame: clear the fields of the previous header
                nxt.magic_lo = in_byte;
                nxt.exp_csum = 8'h00;
                nxt.version  = 8'h00;
                nxt.op       = 8'h00;
                nxt.mask     = 32'h0;
                nxt.size     = 32'h0;
                nxt.size_ovf = 1'b0;
            end
            else if (p == hdr_pos_t'(POS_MAGIC_HI))
            begin
                if ({in_byte, cur.magic_lo} != cfg.magic)
                begin
                    res.status  = ST_BAD_MAGIC;
                    nxt.hdr_pos = '0;
                end
            end
            else if (p == hdr_pos_t'(POS_CSUM))
            begin
                nxt.exp_csum = in_byte;
            end
            else if (p == hdr_pos_t'(POS_VERSION))
            begin
                nxt.version = in_byte;
                if (in_byte > cfg.max_version)
                begin
                    res.status  = ST_BAD_VERSION;
                    nxt.hdr_pos = '0;
                end
            end
            else if (p == hdr_pos_t'(POS_OP))
            begin
                nxt.op = in_byte;
            end

            for (int k = 0; k < 4; k++)
            begin
                if (p == hdr_pos_t'(POS_MASK0 + k))
                    nxt.mask[8*k +: 8] = in_byte;
                if (p == hdr_pos_t'(POS_SIZE0 + k))
                    nxt.size[8*k +: 8] = in_byte;
            end

            // size bytes past the fourth must be zero
            if ((p >= hdr_pos_t'(POS_SIZE0 + 4)) && (in_byte != 8'h00))
                nxt.size_ovf = 1'b1;

            if (p == hdr_pos_t'(POS_LAST))
            begin
                nxt.hdr_pos = '0;
                if (nxt.size_ovf || (nxt.size > cfg.max_size))
                begin
                    res.status = ST_SIZE_LARGE;
                end
                else
                begin
                    res.status     = ST_HDR_OK;
                    nxt.run_csum   = 8'h00;
                    nxt.mask_phase = 2'd0;
                    nxt.remaining  = nxt.size;
                    if (nxt.size == 32'h0)
                    begin
                        res.frame_end   = 1'b1;
                        res.checksum_ok = (cur.exp_csum == 8'h00);
                    end
                    else
                    begin
                        nxt.in_payload = 1'b1;
                    end
                end
            end
        end

        res.frame_op      = nxt.op;
        res.frame_version = nxt.version;
        res.payload_size  = nxt.size;
    end

endmodule

// ----- src/mfd_out_reg.sv -----
`timescale 1ns / 1ps

module mfd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  mfd_pkg::result_t res,
    output logic             can_load,
    mfd_out_if.source        out_ch
);
    import mfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // a new word may enter when the slot is empty or is drained this cycle
    assign can_load   = !valid_reg || out_ch.ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.status        = res_reg.status;
    assign out_ch.data_byte     = res_reg.data_byte;
    assign out_ch.frame_op      = res_reg.frame_op;
    assign out_ch.frame_version = res_reg.frame_version;
    assign out_ch.payload_size  = res_reg.payload_size;
    assign out_ch.frame_end     = res_reg.frame_end;
    assign out_ch.checksum_ok   = res_reg.checksum_ok;

endmodule

// ----- src/masked_frame_deframer.sv -----
// Masked frame deframer.
// in_ch  : one raw stream byte per word (valid/ready, taken when both high).
// out_ch : one result word per input word: status, unmasked data byte, the
//          op/version/size fields of the current header, frame_end and
//          checksum_ok.
// cfg_ch : register writes, index 0 magic, 1 max version, 2 max payload size.
//          Always ready; write only while the block is idle.
// Latency: the result for a byte is on out_ch the cycle after it is taken.
// Throughput: one byte per cycle unless out_ch stalls. The parser state and
// the result register are updated in the same cycle from one short pass of
// compare/XOR/decrement logic, so bytes can follow back to back.
// Stall: out_ch holds one result word; while it is stalled in_ch.ready drops,
// and rises again in the cycle the receiver takes the word.
// Reset: parser returns to header byte 0, output empty, registers go to
// magic 0, max version 1, max size all ones.
// A rejected header (bad magic, version or size) restarts the parse on the
// very next byte.
`timescale 1ns / 1ps

module masked_frame_deframer (
    input  logic      clk,
    input  logic      rst_n,
    mfd_in_if.sink    in_ch,
    mfd_out_if.source out_ch,
    mfd_cfg_if.sink   cfg_ch
);
    import mfd_pkg::*;

    cfg_t         cfg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res;
    logic         can_load;
    logic         take;

    mfd_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    mfd_step u_step (
        .cur     (state_reg),
        .cfg     (cfg),
        .in_byte (in_ch.in_byte),
        .nxt     (state_next),
        .res     (res)
    );

    assign in_ch.ready = can_load;
    assign take        = in_ch.valid && can_load;

    // parser state advances only on an accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (take)
            state_reg <= state_next;
    end

    mfd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .res      (res),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

// ----- src/mfd_checker.sv -----
`timescale 1ns / 1ps

module mfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [7:0]  data_byte,
    input logic [31:0] payload_size,
    input logic        frame_end,
    input logic        checksum_ok
);
    import mfd_pkg::*;

    // every taken byte yields a result word in the next cycle
    a_one_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after accepted byte");

    // frame end only on header accept or payload words
    a_frame_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> (status == ST_HDR_OK || status == ST_PAYLOAD))
        else $error("frame_end on wrong status");

    // checksum flag only at frame end; data only on payload words
    a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!checksum_ok || frame_end) &&
                      (status == ST_PAYLOAD || data_byte == 8'h00))
        else $error("checksum_ok or data_byte out of place");

    // a stalled result word holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
                                    $stable(payload_size) && $stable(data_byte))
        else $error("result changed while stalled");

endmodule

bind masked_frame_deframer mfd_checker u_mfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .status       (out_ch.status),
    .data_byte    (out_ch.data_byte),
    .payload_size (out_ch.payload_size),
    .frame_end    (out_ch.frame_end),
    .checksum_ok  (out_ch.checksum_ok)
);

// ----- tb/deframe_sb_pkg.sv -----
`timescale 1ns / 1ps

package deframe_sb_pkg;
    import mfd_pkg::*;

    class deframe_scoreboard;
        // limits as last written
        logic [15:0] magic_cfg;
        logic [7:0]  max_ver_cfg;
        logic [31:0] max_size_cfg;

        // parser state
        int          hdr_pos;
        bit          in_payload;
        logic [7:0]  magic_lo;
        logic [7:0]  exp_csum;
        logic [7:0]  run_csum;
        logic [7:0]  version;
        logic [7:0]  op;
        logic [31:0] mask_word;
        logic [31:0] size_acc;
        logic [31:0] remaining;
        logic [1:0]  mask_phase;
        bit          size_ovf;

        result_t     awaited_results[$];
        int unsigned errors;

        function new();
            magic_cfg    = '0;
            max_ver_cfg  = 8'd1;
            max_size_cfg = '1;
            hdr_pos      = 0;
            in_payload   = 1'b0;
            magic_lo     = '0;
            exp_csum     = '0;
            run_csum     = '0;
            version      = '0;
            op           = '0;
            mask_word    = '0;
            size_acc     = '0;
            remaining    = '0;
            mask_phase   = '0;
            size_ovf     = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_MAGIC:    magic_cfg    = value[15:0];
                REG_MAX_VER:  max_ver_cfg  = value[7:0];
                REG_MAX_SIZE: max_size_cfg = value;
                default: ;
            endcase
        endfunction

        // Advance the parser by one accepted stream word and queue its result.
        function void note_byte(logic [7:0] b);
            result_t r;
            int      p;
            int      j;
            r = '0;
            r.status = ST_HDR_BYTE;
            if (in_payload) begin
                r.data_byte = b ^ mask_word[8*mask_phase +: 8];
                run_csum    = run_csum ^ r.data_byte;
                mask_phase  = mask_phase + 2'd1;
                remaining   = remaining - 32'd1;
                r.status    = ST_PAYLOAD;
                if (remaining == 0) begin
                    r.frame_end   = 1'b1;
                    r.checksum_ok = (run_csum == exp_csum);
                    in_payload    = 1'b0;
                    hdr_pos       = 0;
                end
            end
            else begin
                p = hdr_pos;
                hdr_pos = p + 1;
                if (p == POS_MAGIC_LO) begin
                    // new header: fields not yet seen read as zero
                    magic_lo  = b;
                    exp_csum  = '0;
                    version   = '0;
                    op        = '0;
                    mask_word = '0;
                    size_acc  = '0;
                    size_ovf  = 1'b0;
                end
                else if (p == POS_MAGIC_HI) begin
                    if ({b, magic_lo} != magic_cfg) begin
                        r.status = ST_BAD_MAGIC;
                        hdr_pos  = 0;
                    end
                end
                else if (p == POS_CSUM)
                    exp_csum = b;
                else if (p == POS_VERSION) begin
                    version = b;
                    if (b > max_ver_cfg) begin
                        r.status = ST_BAD_VERSION;
                        hdr_pos  = 0;
                    end
                end
                else if (p == POS_OP)
                    op = b;
                else if (p < POS_SIZE0)
                    mask_word[8*(p-POS_MASK0) +: 8] = b;
                else begin
                    j = p - POS_SIZE0;
                    if (j < 4)
                        size_acc[8*j +: 8] = b;
                    else if (b != 8'h00)
                        size_ovf = 1'b1;
                    if (p == POS_LAST) begin
                        hdr_pos = 0;
                        if (size_ovf || size_acc > max_size_cfg)
                            r.status = ST_SIZE_LARGE;
                        else begin
                            r.status   = ST_HDR_OK;
                            run_csum   = '0;
                            mask_phase = '0;
                            remaining  = size_acc;
                            if (size_acc == 0) begin
                                r.frame_end   = 1'b1;
                                r.checksum_ok = (exp_csum == 8'h00);
                            end
                            else
                                in_payload = 1'b1;
                        end
                    end
                end
            end
            r.frame_op      = op;
            r.frame_version = version;
            r.payload_size  = size_acc;
            awaited_results.push_back(r);
        endfunction

        function bit differs(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit      bad;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual status %0h",
                         $time, got.status);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            bad = differs("status", want.status, got.status)
                | differs("data_byte", want.data_byte, got.data_byte)
                | differs("frame_op", want.frame_op, got.frame_op)
                | differs("frame_version", want.frame_version, got.frame_version)
                | differs("payload_size", want.payload_size, got.payload_size)
                | differs("frame_end", want.frame_end, got.frame_end)
                | differs("checksum_ok", want.checksum_ok, got.checksum_ok);
            if (bad)
                errors++;
        endfunction
    endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mfd_pkg::*;
    import deframe_sb_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    mfd_in_if  in_ch();
    mfd_out_if out_ch();
    mfd_cfg_if cfg_ch();

    masked_frame_deframer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    deframe_scoreboard sb = new();

    // Limits currently loaded in the block; frame generation keys off these.
    logic [15:0] cur_magic    = 16'h0000;
    logic [7:0]  cur_max_ver  = 8'd1;
    logic [31:0] cur_max_size = 32'hFFFF_FFFF;

    // Percent chance per word / per cycle that an idle burst starts.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned bytes_sent    = 0;

    always #5 clk = ~clk;

    // Watch all three channels at the edge; a word taken here is noted before
    // any result in the same edge is checked (a result always trails its word anyway).
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_idx_t'(cfg_ch.index), cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.note_byte(in_ch.in_byte);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(result_t'({out_ch.status, out_ch.data_byte, out_ch.frame_op,
                                           out_ch.frame_version, out_ch.payload_size,
                                           out_ch.frame_end, out_ch.checksum_ok}));
        end
    end

    // Receiver: ready drops in bursts of random length.
    initial begin
        out_ch.ready <= 1'b1;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Offer one stream word; valid stays high afterwards so back-to-back words
    // never see a low/high pair in the same step. Gaps lower it first.
    task automatic send_byte(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    // Hold the sender off until every result is back. Each word yields a
    // registered result, so a short pause after that leaves it idle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (sb.awaited_results.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Drain, walk the parser back to a frame boundary, then load new limits.
    task automatic start_phase(input logic [15:0] m, input logic [7:0] v, input logic [31:0] s);
        settle();
        // Zero words always finish a header (one begun with zeros ends in bad magic
        // or an empty frame) or run out a short payload under the old limits.
        while (sb.hdr_pos != 0 || sb.in_payload) begin
            send_byte(8'h00);
            settle();
        end
        cfg_write(REG_MAGIC, {16'h0000, m});
        cfg_write(REG_MAX_VER, {24'h000000, v});
        cfg_write(REG_MAX_SIZE, s);
        cfg_ch.valid <= 1'b0;
        cur_magic    = m;
        cur_max_ver  = v;
        cur_max_size = s;
    endtask

    // One frame on the wire: the first hdr_len header words, then pay_len
    // masked payload words. The checksum covers the unmasked payload.
    task automatic send_frame(input logic [15:0] magic, input logic [7:0] ver,
                              input logic [7:0] op, input logic [31:0] mask,
                              input logic [31:0] size_field, input int unsigned pay_len,
                              input bit bad_csum, input int unsigned hdr_len);
        logic [7:0] hdr [HEADER_BYTES];
        logic [7:0] plain [$];
        logic [7:0] csum;
        int         i;
        csum = 8'h00;
        for (i = 0; i < pay_len; i++) begin
            plain.push_back(8'($urandom));
            csum ^= plain[i];
        end
        if (bad_csum)
            csum ^= 8'($urandom_range(1, 255));
        hdr[POS_MAGIC_LO] = magic[7:0];
        hdr[POS_MAGIC_HI] = magic[15:8];
        hdr[POS_CSUM]     = csum;
        hdr[POS_VERSION]  = ver;
        hdr[POS_OP]       = op;
        for (i = 0; i < 4; i++)
            hdr[POS_MASK0 + i] = mask[8*i +: 8];
        for (i = 0; i < SIZE_FIELD_BYTES; i++)
            hdr[POS_SIZE0 + i] = (i < 4) ? size_field[8*i +: 8] : 8'h00;
        for (i = 0; i < hdr_len; i++)
            send_byte(hdr[i]);
        for (i = 0; i < pay_len; i++)
            send_byte(plain[i] ^ mask[8*(i % 4) +: 8]);
    endtask

    // Mostly good frames with random content; the rest are rejections,
    // bad checksums and, unless clean_only, cut-off headers and line noise.
    task automatic send_random_frame(input bit clean_only);
        int unsigned pick;
        int unsigned cap;
        int unsigned hdr_len;
        int unsigned pay_len;
        logic [15:0] magic;
        logic [7:0]  ver;
        logic [31:0] mask;
        logic [31:0] size_field;
        bit          bad_csum;
        pick  = $urandom_range(0, 99);
        magic = cur_magic;
        ver   = 8'($urandom_range(0, cur_max_ver));
        mask  = $urandom;
        case ($urandom_range(0, 7))
            0: mask = '0;
            1: mask = '1;
            default: ;
        endcase
        // short payloads, now and then a longer one
        cap = ($urandom_range(0, 9) == 0) ? 64 : 12;
        if (cur_max_size < cap)
            cap = cur_max_size;
        size_field = $urandom_range(0, cap);
        hdr_len    = HEADER_BYTES;
        bad_csum   = 1'b0;
        if (pick < 10)
            bad_csum = 1'b1;
        else if (pick < 16) begin
            magic   ^= 16'($urandom_range(1, 65535));
            hdr_len  = POS_MAGIC_HI + 1;
        end
        else if (pick < 22 && cur_max_ver != 8'hFF) begin
            ver     = 8'($urandom_range(cur_max_ver + 1, 255));
            hdr_len = POS_VERSION + 1;
        end
        else if (pick < 28 && cur_max_size != 32'hFFFF_FFFF) begin
            size_field = cur_max_size + 32'd1 + ($urandom % (32'hFFFF_FFFF - cur_max_size));
            if ($urandom_range(0, 3) == 0)
                size_field = 32'hFFFF_FFFF;
        end
        else if (pick < 34 && !clean_only)
            hdr_len = $urandom_range(1, HEADER_BYTES - 1);
        else if (pick < 38 && !clean_only) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            return;
        end
        pay_len = (hdr_len == HEADER_BYTES && size_field <= cur_max_size) ? size_field : 0;
        send_frame(magic, ver, 8'($urandom), mask, size_field, pay_len, bad_csum, hdr_len);
    endtask

    initial begin
        int unsigned phase_no;
        int unsigned stop_at;

        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_MAGIC;
        cfg_ch.data   <= 32'h0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset limits: magic 0, max version 1, no size cap ---
        // empty payload, zero checksum -> ends with checksum ok
        send_frame(16'h0000, 8'd1, 8'h00, 32'h0, 32'd0, 0, 1'b0, HEADER_BYTES);
        // empty payload, nonzero checksum byte -> ends with checksum bad
        send_frame(16'h0000, 8'd0, 8'h7E, 32'h0, 32'd0, 0, 1'b1, HEADER_BYTES);
        // high magic byte wrong, low one right
        send_frame(16'h8000, 8'd0, 8'h00, 32'h0, 32'd0, 0, 1'b0, POS_MAGIC_HI + 1);
        // version far above the limit
        send_frame(16'h0000, 8'hFF, 8'h00, 32'h0, 32'd0, 0, 1'b0, POS_VERSION + 1);
        // payload longer than the mask, so the mask phase wraps
        send_frame(16'h0000, 8'd1, 8'hFF, 32'hA5C3_0FF0, 32'd6, 6, 1'b0, HEADER_BYTES);
        // one payload word, checksum mismatch
        send_frame(16'h0000, 8'd0, 8'h81, 32'hFFFF_FFFF, 32'd1, 1, 1'b1, HEADER_BYTES);

        // --- extremes: all-ones magic, any version, only empty frames allowed ---
        start_phase(16'hFFFF, 8'hFF, 32'd0);
        send_frame(16'hFFFF, 8'hFF, 8'h01, 32'h0, 32'd1, 0, 1'b0, HEADER_BYTES);
        send_frame(16'hFFFF, 8'hFF, 8'h02, 32'h0, 32'hFFFF_FFFF, 0, 1'b0, HEADER_BYTES);
        send_frame(16'hFFFF, 8'hFF, 8'h03, 32'h0, 32'd0, 0, 1'b0, HEADER_BYTES);

        // --- version 0 only, size cap 3 ---
        start_phase(16'h5AA5, 8'd0, 32'd3);
        send_frame(16'h5AA5, 8'd0, 8'h10, 32'h1234_5678, 32'd3, 3, 1'b0, HEADER_BYTES);
        send_frame(16'h5AA5, 8'd0, 8'h11, 32'h0, 32'd4, 0, 1'b0, HEADER_BYTES);
        send_frame(16'h5AA5, 8'd1, 8'h12, 32'h0, 32'd0, 0, 1'b0, POS_VERSION + 1);

        // --- random phases; each starts drained, which also covers the
        //     sender holding off until every result is in ---
        for (phase_no = 0; bytes_sent < 880; phase_no++) begin
            case (phase_no % 4)
                0: start_phase(16'($urandom), 8'($urandom), $urandom_range(16, 300));
                1: start_phase((phase_no % 8 == 1) ? 16'hFFFF : 16'h0000, 8'd0, 32'd0);
                2: start_phase(16'($urandom), 8'hFF, $urandom_range(1, 80));
                default: start_phase(16'($urandom), 8'($urandom), 32'hFFFF_FFFF);
            endcase
            send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            stall_pct     = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            stop_at = bytes_sent + $urandom_range(100, 200);
            // with no size cap a stray header could swallow the rest of the
            // run, so that phase gets only frames that keep the parser in step
            while (bytes_sent < stop_at)
                send_random_frame(phase_no % 4 == 3);
        end

        // --- closing stretch at full rate, no gaps on either side ---
        start_phase(16'($urandom), 8'($urandom_range(1, 8)), $urandom_range(16, 120));
        send_idle_pct = 0;
        stall_pct     = 0;
        while (bytes_sent < 1000)
            send_random_frame(1'b0);

        settle();
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
